// ----- design/ookrct_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ookrct_pkg
// Shared types, constants and the code ROM of the OOK remote code transmitter.
// ----------------------------------------------------------------------------
package ookrct_pkg;

   // Field and register widths
   localparam int SLOT_W    = 16;
   localparam int GAP_W     = 20;
   localparam int REP_W     = 4;
   localparam int TICK_W    = 20;
   localparam int DIR_W     = 2;
   localparam int TGT_W     = 2;
   localparam int CSEL_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 20;
   localparam int ROM_W     = 128;
   localparam int ROM_POS_W = 7;

   localparam int CODE_BITS_DEF = 76;

   // Register reset values
   localparam logic [SLOT_W-1:0] SLOT_TICKS_RST   = 16'd330;
   localparam logic [GAP_W-1:0]  GAP_TICKS_RST    = 20'd10000;
   localparam logic [REP_W-1:0]  REPEAT_COUNT_RST = 4'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_COUNT = 2'd2;

   // Command, direction and target codes
   localparam logic              CMD_START  = 1'b1;
   localparam logic [DIR_W-1:0]  DIR_UP     = 2'd0;
   localparam logic [DIR_W-1:0]  DIR_DOWN   = 2'd1;
   localparam logic [DIR_W-1:0]  DIR_STOP   = 2'd2;
   localparam logic [TGT_W-1:0]  TGT_RIGHT  = 2'd2;
   localparam logic [TGT_W-1:0]  TGT_ALL    = 2'd3;
   localparam logic [CSEL_W-1:0] SLOT_FIRST = 2'd0;
   localparam logic [CSEL_W-1:0] SLOT_LAST  = 2'd2;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_ticks;
      logic [GAP_W-1:0]  gap_ticks;
      logic [REP_W-1:0]  repeat_count;
   } cfg_type;

   // Sequencer state without the bit position (its width follows CODE_BITS)
   typedef struct packed {
      logic              active;
      logic [DIR_W-1:0]  latched_direction;
      logic [TGT_W-1:0]  latched_target;
      logic [CSEL_W-1:0] code_slot;
      logic [REP_W-1:0]  repeat_index;
      logic              in_gap;
      logic [TICK_W-1:0] tick_count;
   } state_type;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic done_res;
      logic start_ignored;
   } result_type;

   // Code ROM: rows by direction, columns by target slot; 76-bit codes
   function automatic logic [ROM_W-1:0] rom_word(input logic [DIR_W-1:0]  dir,
                                                 input logic [CSEL_W-1:0] slot);
      logic [75:0] w;
      w = 76'h0;
      case ({dir, slot})
         {DIR_UP,   2'd0}: w = 76'hb6d92592c92d965b248;
         {DIR_UP,   2'd1}: w = 76'hb6d92492d924965b248;
         {DIR_UP,   2'd2}: w = 76'hb6cb65b6cb25965b248;
         {DIR_DOWN, 2'd0}: w = 76'hb6d92592c92d965b2c8;
         {DIR_DOWN, 2'd1}: w = 76'hb6d92492d924965b2c8;
         {DIR_DOWN, 2'd2}: w = 76'hb6cb65b6cb25965b2c8;
         {DIR_STOP, 2'd0}: w = 76'hb6d92592c92d965b258;
         {DIR_STOP, 2'd1}: w = 76'hb6d92492d924965b258;
         {DIR_STOP, 2'd2}: w = 76'hb6cb65b6cb25965b258;
         default:          w = 76'h0;
      endcase
      return {{(ROM_W-76){1'b0}}, w};
   endfunction

endpackage
`default_nettype wire

// ----- design/ookrct_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ookrct_step
// One tick of the transmit sequencer: start handling, slot and gap counting,
// code and repeat advance, and the pin level from the code ROM.
// ----------------------------------------------------------------------------
module ookrct_step #(
   parameter int CODE_BITS = ookrct_pkg::CODE_BITS_DEF,
   localparam int BIT_W    = $clog2(CODE_BITS)
) (
   input  ookrct_pkg::cfg_type               cfg,
   input  ookrct_pkg::state_type             cur_state,
   input  logic [BIT_W-1:0]                  cur_bit,
   input  logic                              command,
   input  logic [ookrct_pkg::DIR_W-1:0]      direction,
   input  logic [ookrct_pkg::TGT_W-1:0]      target,
   output ookrct_pkg::state_type             nxt_state,
   output logic [BIT_W-1:0]                  nxt_bit,
   output ookrct_pkg::result_type            result
);
   import ookrct_pkg::*;

   localparam logic [BIT_W-1:0]     BIT_LAST = BIT_W'(CODE_BITS - 1);
   localparam logic [ROM_POS_W-1:0] POS_TOP  = ROM_POS_W'(CODE_BITS - 1);

   logic [SLOT_W-1:0]    slot_eff;
   logic [REP_W-1:0]     reps_eff;
   logic [ROM_W-1:0]     word;
   logic [ROM_POS_W-1:0] pos;

   assign slot_eff = (cfg.slot_ticks == '0) ? SLOT_W'(1) : cfg.slot_ticks;
   assign reps_eff = (cfg.repeat_count == '0) ? REP_W'(1) : cfg.repeat_count;

   always_comb begin
      state_type         s;
      logic [BIT_W-1:0]  b;
      logic [TICK_W-1:0] tick_next;
      logic [REP_W-1:0]  rep_next;
      logic              finish;
      logic              pin;
      logic              done;
      logic              ignored;

      s       = cur_state;
      b       = cur_bit;
      finish  = 1'b0;
      pin     = 1'b0;
      done    = 1'b0;
      ignored = 1'b0;
      word    = '0;
      pos     = '0;

      if (command == CMD_START) begin
         if (s.active) begin
            ignored = 1'b1;
         end else begin
            s.active            = 1'b1;
            s.latched_direction = (direction > DIR_STOP) ? DIR_STOP : direction;
            s.latched_target    = target;
            s.code_slot         = (target == TGT_ALL) ? SLOT_FIRST : target;
            s.repeat_index      = '0;
            b                   = '0;
            s.in_gap            = 1'b0;
            s.tick_count        = '0;
         end
      end

      tick_next = s.tick_count + 1'b1;

      if (s.active) begin
         if (!s.in_gap) begin
            word = rom_word(s.latched_direction, s.code_slot);
            pos  = POS_TOP - ROM_POS_W'(b);
            pin  = word[pos];
            if (tick_next >= TICK_W'(slot_eff)) begin
               s.tick_count = '0;
               if (b == BIT_LAST) begin
                  b = '0;
                  if (cfg.gap_ticks == '0) begin
                     finish = 1'b1;
                  end else begin
                     s.in_gap = 1'b1;
                  end
               end else begin
                  b = b + 1'b1;
               end
            end else begin
               s.tick_count = tick_next;
            end
         end else begin
            if (tick_next >= cfg.gap_ticks) begin
               finish = 1'b1;
            end else begin
               s.tick_count = tick_next;
            end
         end
      end

      // End of one code and its gap: next target slot, next pass, or idle
      rep_next = s.repeat_index + 1'b1;
      if (finish) begin
         s.in_gap     = 1'b0;
         s.tick_count = '0;
         b            = '0;
         if (s.latched_target == TGT_ALL && s.code_slot < SLOT_LAST) begin
            s.code_slot = s.code_slot + 1'b1;
         end else begin
            s.code_slot = (s.latched_target == TGT_ALL) ? SLOT_FIRST : s.latched_target;
            if (rep_next >= reps_eff || rep_next == '0) begin
               s.active       = 1'b0;
               s.repeat_index = '0;
               s.code_slot    = SLOT_FIRST;
               done           = 1'b1;
            end else begin
               s.repeat_index = rep_next;
            end
         end
      end

      nxt_state            = s;
      nxt_bit              = b;
      result.pin_level     = pin;
      result.busy_res      = s.active;
      result.done_res      = done;
      result.start_ignored = ignored;
   end

endmodule
`default_nettype wire

// ----- design/ook_remote_code_transmitter_core.sv -----
// A word accepted on req_ is held in the input register, then in the result register, before it shows on rsp_.
// Throughput: one word per cycle; the input register refills in the cycle it drains.
// The pace is set by the result register; rsp_ready low holds both registers.
// Reset (synchronous, active high) idles the sequencer, empties both registers and
// loads slot_ticks 330, gap_ticks 10000 and repeat_count 3.
`default_nettype none
// ----------------------------------------------------------------------------
// ook_remote_code_transmitter_core
// OOK radio code transmitter: every word is one tick; a start word latches a
// direction and target and plays the selected codes from ROM, bit by bit,
// each followed by a low gap (none when gap_ticks is zero), for repeat_count passes.
// ----------------------------------------------------------------------------
module ook_remote_code_transmitter_core #(
   parameter int CODE_BITS = ookrct_pkg::CODE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_wr_en,
   input  logic [ookrct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ookrct_pkg::CSR_DAT_W-1:0]  csr_wdata,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [ookrct_pkg::DIR_W-1:0]      req_direction,
   input  logic [ookrct_pkg::TGT_W-1:0]      req_target,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_pin_level,
   output logic                              rsp_busy_res,
   output logic                              rsp_done_res,
   output logic                              rsp_start_ignored
);
   import ookrct_pkg::*;

   localparam int BIT_W = $clog2(CODE_BITS);

   // Configuration registers
   cfg_type cfg_ff, cfg_in;

   // Input register
   logic             in_valid_ff, in_valid_in;
   logic             cmd_ff;
   logic [DIR_W-1:0] dir_ff;
   logic [TGT_W-1:0] tgt_ff;

   // Sequencer state
   state_type        st_ff, st_in;
   logic [BIT_W-1:0] bit_ff, bit_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type res_ff, res_in;

   logic req_fire;
   logic out_free;
   logic advance;

   // Handshake: the input register drains whenever the result register is free
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Register writes; an index past the list is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SLOT_TICKS:   cfg_in.slot_ticks   = csr_wdata[SLOT_W-1:0];
            CSR_GAP_TICKS:    cfg_in.gap_ticks    = csr_wdata[GAP_W-1:0];
            CSR_REPEAT_COUNT: cfg_in.repeat_count = csr_wdata[REP_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   ookrct_step #(
      .CODE_BITS (CODE_BITS)
   ) u_step (
      .cfg       (cfg_ff),
      .cur_state (st_ff),
      .cur_bit   (bit_ff),
      .command   (cmd_ff),
      .direction (dir_ff),
      .target    (tgt_ff),
      .nxt_state (st_in),
      .nxt_bit   (bit_in),
      .result    (res_in)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_ticks   <= SLOT_TICKS_RST;
         cfg_ff.gap_ticks    <= GAP_TICKS_RST;
         cfg_ff.repeat_count <= REPEAT_COUNT_RST;
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         st_ff               <= '0;
         bit_ff              <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // advance the sequencer once per processed word
         if (advance) begin
            st_ff  <= st_in;
            bit_ff <= bit_in;
         end
      end
   end

   // Payload registers: capture on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_command;
         dir_ff <= req_direction;
         tgt_ff <= req_target;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pin_level     = res_ff.pin_level;
   assign rsp_busy_res      = res_ff.busy_res;
   assign rsp_done_res      = res_ff.done_res;
   assign rsp_start_ignored = res_ff.start_ignored;

   // The last tick of a job leaves the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.done_res |-> !res_ff.busy_res)
      else $error("done reported while still busy");

   // A start is only refused by a running job (which may end on that same tick)
   a_ignored_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.start_ignored |-> (res_ff.busy_res || res_ff.done_res))
      else $error("start refused while idle");

   // Gap phase exists only inside a job
   a_gap_active: assert property (@(posedge clock) disable iff (reset)
      st_ff.in_gap |-> st_ff.active)
      else $error("gap phase while idle");

   // Target slot never passes the right-hand code
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      st_ff.code_slot != TGT_ALL)
      else $error("code slot out of range");

   // Idle sequencer keeps its counters cleared
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !st_ff.active |-> (bit_ff == '0 && st_ff.tick_count == '0))
      else $error("counters not cleared while idle");

endmodule
`default_nettype wire

// ----- verif/tb_ook_remote_code_transmitter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ook_remote_code_transmitter_core
// Self-checking bench for the OOK remote code transmitter. A tick-accurate
// transmitter model predicts pin level, busy, done and the ignored-start flag
// for every word. A short directed plan runs first, then random phases with
// fresh register settings. Both channels idle at random, and one phase holds
// the result side off long enough to stall the request side.
// ----------------------------------------------------------------------------
module tb_ook_remote_code_transmitter_core;
   import ookrct_pkg::*;

   localparam int CODE_LEN      = CODE_BITS_DEF;
   localparam int RANDOM_WORDS  = 1950;
   localparam int QUIET_LIMIT   = 2000;   // cycles with no handshake on either side
   localparam int HOLD_CYCLES   = 250;    // result-side hold-off for the pressure phase
   localparam int TAIL_CYCLES   = 8;
   localparam int IDLE_PCT      = 14;
   localparam int SHOWN_FAULTS  = 10;

   // Codes the package leaves unnamed
   localparam logic                 CMD_TICK   = ~CMD_START;
   localparam logic [TGT_W-1:0]     TGT_LEFT   = 2'd0;
   localparam logic [TGT_W-1:0]     TGT_CENTER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // Codes by row direction*3 + target slot (left, center, right)
   localparam logic [CODE_LEN-1:0] REMOTE_CODES [9] = '{
      76'hb6d92592c92d965b248, 76'hb6d92492d924965b248, 76'hb6cb65b6cb25965b248,
      76'hb6d92592c92d965b2c8, 76'hb6d92492d924965b2c8, 76'hb6cb65b6cb25965b2c8,
      76'hb6d92592c92d965b258, 76'hb6d92492d924965b258, 76'hb6cb65b6cb25965b258
   };

   // Result words that can be read straight off the behavior
   localparam result_type RES_IDLE    = 4'b0000;   // nothing running
   localparam result_type RES_MARK    = 4'b1100;   // pin high, busy
   localparam result_type RES_MARK_IG = 4'b1101;   // pin high, busy, start dropped

   typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

   typedef struct packed {
      row_kind_e              kind;
      logic                   command;
      logic [DIR_W-1:0]       direction;
      logic [TGT_W-1:0]       target;
      logic [CSR_IDX_W-1:0]   index;
      logic [CSR_DAT_W-1:0]   wdata;
      logic                   typed;
      result_type             want;
   } plan_row_t;

   // Directed plan: register rows drain the block first, word rows are checked
   // against the typed result where one is given, else against the model.
   localparam plan_row_t PLAN [24] = '{
      // idle ticks with direction and target bits all low, then all high
      '{ROW_WORD, CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_UNUSED, 20'd0, 1'b1, RES_IDLE},
      '{ROW_WORD, CMD_TICK,  2'd3,     TGT_ALL,    CSR_UNUSED, 20'd0, 1'b1, RES_IDLE},
      // start with the out-of-range direction (acts as stop) on all targets
      '{ROW_WORD, CMD_START, 2'd3,     TGT_ALL,    CSR_UNUSED, 20'd0, 1'b1, RES_MARK},
      // start while busy: dropped, but still a tick
      '{ROW_WORD, CMD_START, DIR_UP,   TGT_LEFT,   CSR_UNUSED, 20'd0, 1'b1, RES_MARK_IG},
      '{ROW_WORD, CMD_TICK,  DIR_DOWN, TGT_RIGHT,  CSR_UNUSED, 20'd0, 1'b1, RES_MARK},
      // zero slot, zero gap and zero repeat mid-code; a write to the spare index
      '{ROW_REG,  CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_SLOT_TICKS,   20'd0, 1'b0, RES_IDLE},
      '{ROW_REG,  CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_GAP_TICKS,    20'd0, 1'b0, RES_IDLE},
      '{ROW_REG,  CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_REPEAT_COUNT, 20'd0, 1'b0, RES_IDLE},
      '{ROW_REG,  CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_UNUSED, 20'hFFFFF, 1'b0, RES_IDLE},
      '{ROW_WORD, CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_UNUSED, 20'd0, 1'b0, RES_IDLE},
      '{ROW_WORD, CMD_TICK,  DIR_STOP, TGT_CENTER, CSR_UNUSED, 20'd0, 1'b0, RES_IDLE},
      '{ROW_WORD, CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_UNUSED, 20'd0, 1'b0, RES_IDLE},
      '{ROW_WORD, CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_UNUSED, 20'd0, 1'b0, RES_IDLE},
      '{ROW_WORD, CMD_START, DIR_DOWN, TGT_RIGHT,  CSR_UNUSED, 20'd0, 1'b0, RES_IDLE},
      '{ROW_WORD, CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_UNUSED, 20'd0, 1'b0, RES_IDLE},
      '{ROW_WORD, CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_UNUSED, 20'd0, 1'b0, RES_IDLE},
      // largest settings while the code is still running
      '{ROW_REG,  CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_SLOT_TICKS,   20'hFFFF,  1'b0, RES_IDLE},
      '{ROW_REG,  CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_GAP_TICKS,    20'hFFFFF, 1'b0, RES_IDLE},
      '{ROW_REG,  CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_REPEAT_COUNT, 20'hF,     1'b0, RES_IDLE},
      '{ROW_WORD, CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_UNUSED, 20'd0, 1'b0, RES_IDLE},
      '{ROW_WORD, CMD_START, DIR_STOP, TGT_CENTER, CSR_UNUSED, 20'd0, 1'b0, RES_IDLE},
      '{ROW_WORD, CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_UNUSED, 20'd0, 1'b0, RES_IDLE},
      '{ROW_WORD, CMD_START, DIR_UP,   TGT_ALL,    CSR_UNUSED, 20'd0, 1'b0, RES_IDLE},
      '{ROW_WORD, CMD_TICK,  DIR_UP,   TGT_LEFT,   CSR_UNUSED, 20'd0, 1'b0, RES_IDLE}
   };

   // DUT ports
   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DAT_W-1:0]  csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_command;
   logic [DIR_W-1:0]      req_direction;
   logic [TGT_W-1:0]      req_target;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_pin_level;
   logic                  rsp_busy_res;
   logic                  rsp_done_res;
   logic                  rsp_start_ignored;

   // Transmitter model: sequencer state, bit position and register copy
   state_type  tx_state;
   int         tx_bit_pos;
   cfg_type    tx_cfg;

   result_type tick_results_q [$];   // expected result per word, oldest first

   // Run bookkeeping
   bit         calm = 1'b0;          // both sides stop idling while set
   int         hold_req = 0;
   int         hold_served = 0;
   int         fault_count = 0;
   int         words_sent = 0;
   int         random_words = 0;
   int         results_seen = 0;
   int         dones_seen = 0;
   int         ignores_seen = 0;
   int         settings_loaded = 0;
   int         quiet_cycles = 0;
   int         phase = 0;
   int         phase_len;
   int         pick;
   logic                 w_cmd;
   logic [DIR_W-1:0]     w_dir;
   logic [TGT_W-1:0]     w_tgt;
   logic [SLOT_W-1:0]    new_slot;
   logic [GAP_W-1:0]     new_gap;
   logic [REP_W-1:0]     new_rep;
   result_type           got;
   result_type           want;

   ook_remote_code_transmitter_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_direction     (req_direction),
      .req_target        (req_target),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pin_level     (rsp_pin_level),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_done_res      (rsp_done_res),
      .rsp_start_ignored (rsp_start_ignored)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Close one code and its gap: step to the next target or the next pass,
   // and report whether the whole job is over.
   function automatic logic close_code();
      logic [REP_W-1:0] passes;
      passes = (tx_cfg.repeat_count == '0) ? REP_W'(1) : tx_cfg.repeat_count;
      tx_state.in_gap     = 1'b0;
      tx_state.tick_count = '0;
      tx_bit_pos          = 0;
      if (tx_state.latched_target == TGT_ALL && tx_state.code_slot < SLOT_LAST) begin
         tx_state.code_slot = tx_state.code_slot + 1'b1;
         return 1'b0;
      end
      tx_state.code_slot    = (tx_state.latched_target == TGT_ALL) ? SLOT_FIRST
                                                                   : tx_state.latched_target;
      tx_state.repeat_index = tx_state.repeat_index + 1'b1;
      // a wrap of the 4-bit pass counter also ends the job
      if (tx_state.repeat_index >= passes || tx_state.repeat_index == '0) begin
         tx_state.active       = 1'b0;
         tx_state.repeat_index = '0;
         tx_state.code_slot    = SLOT_FIRST;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advance the model by one word (every word is one tick) and return its result.
   function automatic result_type advance_transmitter(input logic cmd,
                                                      input logic [DIR_W-1:0] dir,
                                                      input logic [TGT_W-1:0] tgt);
      result_type       res;
      logic [TICK_W-1:0] next_count;
      int               slot_limit;
      int               code_row;
      res = RES_IDLE;
      if (cmd == CMD_START) begin
         if (tx_state.active) begin
            res.start_ignored = 1'b1;
         end else begin
            tx_state.active            = 1'b1;
            tx_state.latched_direction = (dir > DIR_STOP) ? DIR_STOP : dir;
            tx_state.latched_target    = tgt;
            tx_state.code_slot         = (tgt == TGT_ALL) ? SLOT_FIRST : tgt;
            tx_state.repeat_index      = '0;
            tx_state.in_gap            = 1'b0;
            tx_state.tick_count        = '0;
            tx_bit_pos                 = 0;
         end
      end
      if (tx_state.active) begin
         next_count = tx_state.tick_count + 1'b1;
         if (!tx_state.in_gap) begin
            slot_limit    = (tx_cfg.slot_ticks == '0) ? 1 : int'(tx_cfg.slot_ticks);
            code_row      = int'(tx_state.latched_direction) * 3 + int'(tx_state.code_slot);
            res.pin_level = REMOTE_CODES[code_row][CODE_LEN-1-tx_bit_pos];
            // ">=" so a slot shortened mid-bit ends at once
            if (int'(next_count) >= slot_limit) begin
               tx_state.tick_count = '0;
               tx_bit_pos++;
               if (tx_bit_pos >= CODE_LEN) begin
                  tx_bit_pos = 0;
                  if (tx_cfg.gap_ticks == '0)
                     res.done_res = close_code();
                  else
                     tx_state.in_gap = 1'b1;
               end
            end else begin
               tx_state.tick_count = next_count;
            end
         end else begin
            if (next_count >= tx_cfg.gap_ticks)
               res.done_res = close_code();
            else
               tx_state.tick_count = next_count;
         end
      end
      res.busy_res = tx_state.active;
      return res;
   endfunction

   task automatic report_fault(input string what);
      fault_count++;
      if (fault_count <= SHOWN_FAULTS)
         $display("[%0t] %s", $time, what);
   endtask

   // Offer one word; entered and left at a falling edge, valid still high on exit.
   task automatic send_word(input logic cmd, input logic [DIR_W-1:0] dir,
                            input logic [TGT_W-1:0] tgt, input logic typed,
                            input result_type typed_res);
      result_type predicted;
      predicted = advance_transmitter(cmd, dir, tgt);
      tick_results_q.push_back(typed ? typed_res : predicted);
      // random bubbles ahead of the word
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_command   = cmd;
      req_direction = dir;
      req_target    = tgt;
      // hold the word until it is taken
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   // Write one register once every expected result is back.
   task automatic load_register(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CSR_DAT_W-1:0] data);
      req_valid = 1'b0;
      while (tick_results_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_SLOT_TICKS:   tx_cfg.slot_ticks   = data[SLOT_W-1:0];
         CSR_GAP_TICKS:    tx_cfg.gap_ticks    = data[GAP_W-1:0];
         CSR_REPEAT_COUNT: tx_cfg.repeat_count = data[REP_W-1:0];
         default: ;   // spare index: drop
      endcase
      settings_loaded++;
   endtask

   // Result side: random stalls, a calm stretch, and one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_served) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_served++;
         end
         rsp_ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Compare every result taken with the oldest expectation, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_pin_level, rsp_busy_res, rsp_done_res, rsp_start_ignored};
         results_seen++;
         if (got.done_res)      dones_seen++;
         if (got.start_ignored) ignores_seen++;
         if (tick_results_q.size() == 0) begin
            report_fault($sformatf("unexpected result pin=%b busy=%b done=%b ign=%b",
                                   got.pin_level, got.busy_res, got.done_res,
                                   got.start_ignored));
         end else begin
            want = tick_results_q.pop_front();
            if (got.pin_level !== want.pin_level || got.busy_res !== want.busy_res ||
                got.done_res !== want.done_res || got.start_ignored !== want.start_ignored)
               report_fault($sformatf(
                  "result %0d: pin %b/%b busy %b/%b done %b/%b ign %b/%b (exp/act)",
                  results_seen, want.pin_level, got.pin_level, want.busy_res,
                  got.busy_res, want.done_res, got.done_res, want.start_ignored,
                  got.start_ignored));
         end
      end
   end

   // Watchdog: give up when neither side has moved a word for too long.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, tick_results_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      req_valid     = 1'b0;
      req_command   = CMD_TICK;
      req_direction = DIR_UP;
      req_target    = TGT_LEFT;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_SLOT_TICKS;
      csr_wdata     = '0;
      reset         = 1'b1;
      tx_state      = '0;
      tx_bit_pos    = 0;
      tx_cfg        = '{SLOT_TICKS_RST, GAP_TICKS_RST, REPEAT_COUNT_RST};
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed plan
      for (int i = 0; i < $size(PLAN); i++) begin
         if (PLAN[i].kind == ROW_REG)
            load_register(PLAN[i].index, PLAN[i].wdata);
         else
            send_word(PLAN[i].command, PLAN[i].direction, PLAN[i].target,
                      PLAN[i].typed, PLAN[i].want);
      end

      // Random phases: new settings while the sequencer may still be mid-code,
      // then mostly well-formed traffic (start when idle, ticks when busy).
      while (random_words < RANDOM_WORDS) begin
         phase++;
         pick     = $urandom_range(0, 99);
         new_slot = (pick < 8) ? 16'd0 : (pick < 70) ? 16'd1 : (pick < 88) ? 16'd2
                                                             : SLOT_W'($urandom_range(3, 6));
         pick     = $urandom_range(0, 99);
         new_gap  = (pick < 10) ? 20'd0 : (pick < 97) ? GAP_W'($urandom_range(1, 8))
                                                      : GAP_W'($urandom_range(9, 40));
         pick     = $urandom_range(0, 99);
         new_rep  = (pick < 8) ? 4'd0 : (pick < 60) ? 4'd1 : (pick < 90) ? 4'd2
                                                     : (pick < 95) ? 4'd3 : 4'd15;
         load_register(CSR_SLOT_TICKS, CSR_DAT_W'(new_slot));
         load_register(CSR_GAP_TICKS, CSR_DAT_W'(new_gap));
         load_register(CSR_REPEAT_COUNT, CSR_DAT_W'(new_rep));

         calm = (phase == 4);
         if (phase == 2)
            hold_req++;   // stall the result side while words keep coming
         phase_len = $urandom_range(40, 160);
         for (int k = 0; k < phase_len; k++) begin
            pick  = $urandom_range(0, 99);
            w_dir = DIR_W'($urandom_range(0, 3));
            w_tgt = TGT_W'($urandom_range(0, 3));
            if (pick < 10)
               w_cmd = 1'($urandom_range(0, 1));          // noise
            else if (!tx_state.active)
               w_cmd = (pick < 65) ? CMD_START : CMD_TICK;
            else
               w_cmd = (pick < 13) ? CMD_START : CMD_TICK;  // occasional dropped start
            send_word(w_cmd, w_dir, w_tgt, 1'b0, RES_IDLE);
            random_words++;
         end
      end
      calm = 1'b0;

      // Drain and let the pipeline settle
      req_valid = 1'b0;
      while (tick_results_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (tick_results_q.size() != 0)
         report_fault($sformatf("%0d results never arrived", tick_results_q.size()));

      $display("Sent %0d words over %0d random phases, %0d register writes.",
               words_sent, phase, settings_loaded);
      $display("Checked %0d results: %0d completed jobs, %0d dropped starts, %0d faults.",
               results_seen, dones_seen, ignores_seen, fault_count);
      if (fault_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- ook_remote_code_transmitter_core.f -----
design/ookrct_pkg.sv
design/ookrct_step.sv
design/ook_remote_code_transmitter_core.sv
verif/tb_ook_remote_code_transmitter_core.sv
